// ===== rtl/aes_pkg.sv =====
// aes_pkg: shared types, constants and functions for the aes block cipher core
// depends on nothing; used by the core, aes_ctrl and aes_dp
package aes_pkg;

  localparam int unsigned MaxRoundWords = 60;
  localparam int unsigned StoreDepth    = 2 * MaxRoundWords;
  localparam int unsigned AddrW         = $clog2(StoreDepth);

  // configuration register indexes
  localparam logic [2:0] REG_KEY0 = 3'd0;
  localparam logic [2:0] REG_KEY1 = 3'd1;
  localparam logic [2:0] REG_KEY2 = 3'd2;
  localparam logic [2:0] REG_KEY3 = 3'd3;
  localparam logic [2:0] REG_KLEN = 3'd4;
  localparam logic [2:0] REG_MODE = 3'd5;
  localparam logic [2:0] REG_IVH  = 3'd6;
  localparam logic [2:0] REG_IVL  = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KEXP_RD,
    ST_KEXP_WAIT,
    ST_KEXP_WR,
    ST_INV_RD,
    ST_INV_WAIT,
    ST_INV_WR,
    ST_LOAD,
    ST_RK_WAIT,
    ST_ROUND,
    ST_OUT
  } aes_state_e;

  // controller to datapath
  typedef struct packed {
    logic start_kexp;  // clear word counters and round constant
    logic kexp_rd;     // read of w[i-nk]; w[i-1] is held in a register
    logic kexp_wr;     // write w[i], advance
    logic inv_rd;      // issue read of forward word
    logic inv_wr;      // write inverse word, advance
    logic load;        // capture input item and start a block
    logic rk_rd;       // read round key for current round
    logic round;       // apply one round
    logic out_load;    // move result into output register
  } aes_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic kexp_done;
    logic inv_done;
    logic last_word;   // current round key word is the last of its group
    logic last_round;
  } aes_stat_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // forward mix of one column
  function automatic logic [31:0] mix_col(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
    return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
            xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  // inverse mix of one column
  function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    a[0] = w[31:24]; a[1] = w[23:16]; a[2] = w[15:8]; a[3] = w[7:0];
    for (int k = 0; k < 4; k++) begin
      x2[k] = xtime(a[k]);
      x4[k] = xtime(x2[k]);
      x8[k] = xtime(x4[k]);
      m9[k] = x8[k] ^ a[k];
      mb[k] = x8[k] ^ x2[k] ^ a[k];
      md[k] = x8[k] ^ x4[k] ^ a[k];
      me[k] = x8[k] ^ x4[k] ^ x2[k];
    end
    return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
            m9[0] ^ me[1] ^ mb[2] ^ md[3],
            md[0] ^ m9[1] ^ me[2] ^ mb[3],
            mb[0] ^ md[1] ^ m9[2] ^ me[3]};
  endfunction

endpackage

// ===== rtl/aes_block_cipher_ecb_cbc_core.sv =====
// aes block cipher core, ecb and cbc, 128/192/256-bit keys
// a block holds the core from input transfer to result: each round waits for the key
// store read, reads four key words one a cycle, then applies; key expansion and the
// inverse schedule run before the first block after reset or a key change; one block
// at a time.
// reset: async active low; config registers and chain value clear, schedule invalid
module aes_block_cipher_ecb_cbc_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  input  logic        chain_restart_i,
  input  logic        final_block_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] out_high_o,
  output logic [63:0] out_low_o,
  output logic        out_last_o
);
  import aes_pkg::*;

  aes_cmd_t  cmd;
  aes_stat_t stat;
  logic      sched_ready;

  assign cfg_ready_o = 1'b1;

  aes_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sched_ready_i(sched_ready),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  aes_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .block_high_i   (block_high_i),
    .block_low_i    (block_low_i),
    .chain_restart_i(chain_restart_i),
    .final_block_i  (final_block_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .sched_ready_o  (sched_ready),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_high_o     (out_high_o),
    .out_low_o      (out_low_o),
    .out_last_o     (out_last_o)
  );
endmodule

// ===== rtl/aes_ram.sv =====
// aes_ram: generic single-port write, single-port read ram with registered read
// depends on nothing
module aes_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 120
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== rtl/aes_ctrl.sv =====
// aes_ctrl: controller state machine for key expansion and block rounds
// depends on aes_pkg
module aes_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               sched_ready_i,
  input  aes_pkg::aes_stat_t stat_i,
  output aes_pkg::aes_cmd_t  cmd_o
);
  import aes_pkg::*;

  aes_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sched_ready_i ? ST_LOAD : ST_KEXP_RD;
        end
      end
      ST_KEXP_RD:   state_d = ST_KEXP_WAIT;
      ST_KEXP_WAIT: state_d = ST_KEXP_WR;
      ST_KEXP_WR:   state_d = stat_i.kexp_done ? ST_INV_RD : ST_KEXP_RD;
      ST_INV_RD:    state_d = ST_INV_WAIT;
      ST_INV_WAIT:  state_d = ST_INV_WR;
      ST_INV_WR:    state_d = stat_i.inv_done ? ST_LOAD : ST_INV_RD;
      ST_LOAD:      state_d = ST_RK_WAIT;
      ST_RK_WAIT:   state_d = stat_i.last_word ? ST_ROUND : ST_RK_WAIT;
      ST_ROUND:     state_d = stat_i.last_round ? ST_OUT : ST_RK_WAIT;
      ST_OUT: begin
        if (!out_valid_i || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE:    cmd_o.start_kexp = in_valid_i && !sched_ready_i;
      ST_KEXP_RD: cmd_o.kexp_rd = 1'b1;
      ST_KEXP_WR: cmd_o.kexp_wr = 1'b1;
      // keep the forward word address until the write
      ST_INV_RD, ST_INV_WAIT: cmd_o.inv_rd = 1'b1;
      ST_INV_WR:  cmd_o.inv_wr = 1'b1;
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        in_ready_o = 1'b1;
      end
      ST_RK_WAIT: cmd_o.rk_rd = 1'b1;
      ST_ROUND:   cmd_o.round = 1'b1;
      ST_OUT:     cmd_o.out_load = !out_valid_i || out_ready_i;
      default: ;
    endcase
  end
endmodule

// ===== rtl/aes_dp.sv =====
// aes_dp: datapath with config registers, round key store, key expansion,
// round unit, cbc chaining and output register; depends on aes_pkg, aes_ram
module aes_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic [63:0]        block_high_i,
  input  logic [63:0]        block_low_i,
  input  logic               chain_restart_i,
  input  logic               final_block_i,
  input  aes_pkg::aes_cmd_t  cmd_i,
  output aes_pkg::aes_stat_t stat_o,
  output logic               sched_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [63:0]        out_high_o,
  output logic [63:0]        out_low_o,
  output logic               out_last_o
);
  import aes_pkg::*;

  localparam logic [AddrW-1:0] InvBase = AddrW'(MaxRoundWords);

  logic [63:0]  key_q [4];
  logic [1:0]   klen_q, mode_q;
  logic [63:0]  ivh_q, ivl_q;
  logic         sched_q;
  logic [127:0] chain_q;

  // configuration registers; key and key length writes drop the schedule
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) key_q[k] <= '0;
      klen_q  <= '0;
      mode_q  <= '0;
      ivh_q   <= '0;
      ivl_q   <= '0;
      sched_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
            key_q[cfg_index_i[1:0]] <= cfg_data_i;
            sched_q <= 1'b0;
          end
          REG_KLEN: begin
            klen_q  <= cfg_data_i[1:0];
            sched_q <= 1'b0;
          end
          REG_MODE: mode_q <= cfg_data_i[1:0];
          REG_IVH:  ivh_q <= cfg_data_i;
          REG_IVL:  ivl_q <= cfg_data_i;
          default: ;
        endcase
      end else if (cmd_i.inv_wr && stat_o.inv_done) begin
        sched_q <= 1'b1;
      end
    end
  end
  assign sched_ready_o = sched_q;

  // key size: nk words, nr rounds
  logic [3:0] nr;
  logic [3:0] nk;
  always_comb begin
    unique case (klen_q)
      2'd0:    nr = 4'd10;
      2'd1:    nr = 4'd12;
      default: nr = 4'd14;
    endcase
    nk = nr - 4'd6;
  end
  logic [5:0] nwords;
  assign nwords = {nr, 2'b00} + 6'd4;

  // key expansion counters
  logic [5:0] wi_q;     // word index being produced
  logic [2:0] wmod_q;   // wi mod nk
  logic [7:0] rcon_q;
  logic [31:0] prev_q;  // w[i-1]
  logic [3:0] ir_q;     // inverse pass round
  logic [1:0] ij_q;     // inverse pass column

  // ram ports
  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [31:0]      wdata, rdata;

  aes_ram #(.Width(32), .Depth(StoreDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // key word selected from config for the first nk words
  logic [31:0] key_init;
  always_comb begin
    logic [63:0] kw;
    kw = key_q[wi_q[2:1]];
    key_init = wi_q[0] ? kw[31:0] : kw[63:32];
  end

  // next expanded word
  logic [31:0] temp, new_word;
  always_comb begin
    temp = prev_q;
    if (wmod_q == 3'd0) begin
      temp = sub_word({prev_q[23:0], prev_q[31:24]}) ^ {rcon_q, 24'h0};
    end else if (nk > 4'd6 && wmod_q == 3'd4) begin
      temp = sub_word(prev_q);
    end
    new_word = ({2'b00, wi_q} < {2'b00, nk, 2'b00} >> 2) ? key_init : (rdata ^ temp);
  end

  // round state
  logic [127:0] st_q;
  logic [3:0]   rnd_q;
  logic [1:0]   col_q;
  logic [127:0] rk_q;
  logic         dec_q, cbc_q, last_q;
  logic [127:0] in_q;
  logic         rk_valid_q;

  // column addressed one ahead of the column being captured
  logic [1:0] rk_col;
  assign rk_col = col_q + {1'b0, rk_valid_q};

  // ram addressing
  always_comb begin
    we    = 1'b0;
    waddr = AddrW'(wi_q);
    wdata = new_word;
    raddr = AddrW'(wi_q - {2'b00, nk});
    if (cmd_i.kexp_wr) begin
      we = 1'b1;
    end
    if (cmd_i.inv_rd || cmd_i.inv_wr) begin
      raddr = AddrW'({nr - ir_q, ij_q});
      waddr = InvBase + AddrW'({ir_q, ij_q});
      wdata = (ir_q == 4'd0 || ir_q == nr) ? rdata : inv_mix_col(rdata);
      we    = cmd_i.inv_wr;
    end
    if (cmd_i.rk_rd) begin
      raddr = dec_q ? InvBase + AddrW'({rnd_q, rk_col}) : AddrW'({rnd_q, rk_col});
    end
    if (cmd_i.load) begin
      raddr = mode_q[0] ? InvBase : '0;
    end
  end

  // expansion and inverse pass counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q   <= '0;
      wmod_q <= '0;
      rcon_q <= 8'h01;
      ir_q   <= '0;
      ij_q   <= '0;
      prev_q <= '0;
    end else begin
      if (cmd_i.start_kexp) begin
        wi_q   <= '0;
        wmod_q <= '0;
        rcon_q <= 8'h01;
        ir_q   <= '0;
        ij_q   <= '0;
      end
      if (cmd_i.kexp_wr) begin
        prev_q <= new_word;
        wi_q   <= wi_q + 6'd1;
        if ({1'b0, wmod_q} == nk - 4'd1) begin
          wmod_q <= '0;
        end else begin
          wmod_q <= wmod_q + 3'd1;
        end
        if (wmod_q == 3'd0 && wi_q >= {2'b00, nk}) begin
          rcon_q <= xtime(rcon_q);
        end
      end
      if (cmd_i.inv_wr) begin
        ij_q <= ij_q + 2'd1;
        if (ij_q == 2'd3) ir_q <= ir_q + 4'd1;
      end
    end
  end

  assign stat_o.kexp_done  = (wi_q == nwords - 6'd1);
  assign stat_o.inv_done   = (ir_q == nr) && (ij_q == 2'd3);
  assign stat_o.last_word  = rk_valid_q && (col_q == 2'd3);
  assign stat_o.last_round = (rnd_q == nr);

  // one round on the whole state
  function automatic logic [127:0] do_round(input logic [127:0] s, input logic dec,
                                            input logic fin, input logic [127:0] k);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int c = 0; c < 4; c++) begin
      for (int q = 0; q < 4; q++) begin
        if (dec) t[4*((c+q)%4)+q] = inv_sbox(b[4*c+q]);
        else     t[4*c+q] = sbox(b[4*((c+q)%4)+q]);
      end
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = t[i];
    if (!fin) begin
      for (int c = 0; c < 4; c++) begin
        r[127-32*c -: 32] = dec ? inv_mix_col(r[127-32*c -: 32])
                                : mix_col(r[127-32*c -: 32]);
      end
    end
    return r ^ k;
  endfunction

  // block sequencing: load, gather round key words, apply round
  logic [127:0] chain_src;
  assign chain_src = chain_restart_i ? {ivh_q, ivl_q} : chain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q    <= '0;
      rnd_q      <= '0;
      col_q      <= '0;
      rk_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        chain_q    <= chain_src;
        rnd_q      <= '0;
        col_q      <= '0;
        rk_valid_q <= 1'b0;
      end
      if (cmd_i.rk_rd) begin
        rk_valid_q <= 1'b1;
        if (rk_valid_q) begin
          col_q <= col_q + 2'd1;
          if (col_q == 2'd3) rk_valid_q <= 1'b0;
        end
      end
      if (cmd_i.round) begin
        rnd_q <= rnd_q + 4'd1;
      end
      // chain moves on once the result has used the old value
      if (cmd_i.out_load && cbc_q) begin
        chain_q <= dec_q ? in_q : st_q;
      end
    end
  end

  // state and key registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q   <= {block_high_i, block_low_i};
      st_q   <= {block_high_i, block_low_i} ^
                ((mode_q == 2'd2) ? chain_src : 128'h0);
      dec_q  <= mode_q[0];
      cbc_q  <= mode_q[1];
      last_q <= final_block_i;
    end
    if (cmd_i.rk_rd && rk_valid_q) begin
      rk_q[127-32*col_q -: 32] <= rdata;
    end
    if (cmd_i.round) begin
      st_q <= (rnd_q == 4'd0) ? (st_q ^ rk_q)
                              : do_round(st_q, dec_q, rnd_q == nr, rk_q);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      {out_high_o, out_low_o} <= (cbc_q && dec_q) ? (st_q ^ chain_q) : st_q;
      out_last_o <= last_q;
    end
  end
endmodule

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for the aes ecb/cbc core
// depends on aes_pkg (register indexes) and aes_block_cipher_ecb_cbc_core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import aes_pkg::*;

  localparam logic [1:0] MODE_ECB_ENC = 2'd0;
  localparam logic [1:0] MODE_ECB_DEC = 2'd1;
  localparam logic [1:0] MODE_CBC_ENC = 2'd2;
  localparam logic [1:0] MODE_CBC_DEC = 2'd3;
  localparam logic [1:0] KLEN_128 = 2'd0;
  localparam logic [1:0] KLEN_192 = 2'd1;
  localparam logic [1:0] KLEN_256 = 2'd2;
  localparam logic [1:0] KLEN_ODD = 2'd3;
  localparam int IdleLimit = 4000;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        restart;
    logic        last;
  } blk_item_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        last;
  } blk_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [63:0] block_high_i = '0;
  logic [63:0] block_low_i = '0;
  logic        chain_restart_i = 1'b0;
  logic        final_block_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] out_high_o;
  logic [63:0] out_low_o;
  logic        out_last_o;

  aes_block_cipher_ecb_cbc_core uut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [63:0]  reg_shadow [8];
  logic [127:0] chain_shadow;
  logic [7:0]   fwd_sb [256];
  logic [7:0]   inv_sb [256];
  logic [31:0]  round_keys [60];
  int           num_rounds;

  blk_item_t   block_q [$];
  blk_result_t cipher_out_q [$];
  blk_item_t   cur_block;
  int          err_cnt = 0;
  int          n_out = 0;
  int          idle_cycles = 0;
  bit          no_gaps = 1'b0;

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // s-boxes from the field inverse and the affine map
  function void build_boxes();
    logic [7:0] inv, b;
    for (int x = 0; x < 256; x++) begin
      inv = '0;
      for (int y = 1; y < 256; y++)
        if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      fwd_sb[x] = b;
      inv_sb[b] = x[7:0];
    end
  endfunction

  function automatic logic [31:0] subst_word(logic [31:0] w);
    return {fwd_sb[w[31:24]], fwd_sb[w[23:16]], fwd_sb[w[15:8]], fwd_sb[w[7:0]]};
  endfunction

  function automatic logic [31:0] mix_column(logic [31:0] w, bit inverse);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
    if (inverse)
      return {gf_mul(a0, 14) ^ gf_mul(a1, 11) ^ gf_mul(a2, 13) ^ gf_mul(a3, 9),
              gf_mul(a0, 9) ^ gf_mul(a1, 14) ^ gf_mul(a2, 11) ^ gf_mul(a3, 13),
              gf_mul(a0, 13) ^ gf_mul(a1, 9) ^ gf_mul(a2, 14) ^ gf_mul(a3, 11),
              gf_mul(a0, 11) ^ gf_mul(a1, 13) ^ gf_mul(a2, 9) ^ gf_mul(a3, 14)};
    return {gf_mul(a0, 2) ^ gf_mul(a1, 3) ^ a2 ^ a3,
            a0 ^ gf_mul(a1, 2) ^ gf_mul(a2, 3) ^ a3,
            a0 ^ a1 ^ gf_mul(a2, 2) ^ gf_mul(a3, 3),
            gf_mul(a0, 3) ^ a1 ^ a2 ^ gf_mul(a3, 2)};
  endfunction

  // forward key schedule; length code three behaves as 256 bit
  function void expand_schedule();
    int nk, total;
    logic [31:0] t;
    logic [7:0]  rc;
    logic [63:0] kw;
    case (reg_shadow[REG_KLEN][1:0])
      KLEN_128: num_rounds = 10;
      KLEN_192: num_rounds = 12;
      default:  num_rounds = 14;
    endcase
    nk = num_rounds - 6;
    total = 4 * (num_rounds + 1);
    rc = 8'h01;
    for (int i = 0; i < nk; i++) begin
      kw = reg_shadow[REG_KEY0 + (i >> 1)];
      round_keys[i] = (i % 2) ? kw[31:0] : kw[63:32];
    end
    for (int i = nk; i < total; i++) begin
      t = round_keys[i-1];
      if (i % nk == 0) begin
        t = subst_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_mul(rc, 8'h02);
      end else if (nk > 6 && i % nk == 4) begin
        t = subst_word(t);
      end
      round_keys[i] = round_keys[i-nk] ^ t;
    end
  endfunction

  function automatic logic [127:0] run_cipher(logic [127:0] blk, bit dec);
    logic [7:0]  s [16];
    logic [7:0]  t [16];
    logic [31:0] w;
    for (int j = 0; j < 16; j++) s[j] = blk[127-8*j -: 8];
    if (!dec) begin
      for (int j = 0; j < 16; j++) s[j] ^= round_keys[j/4][31-8*(j%4) -: 8];
      for (int r = 1; r <= num_rounds; r++) begin
        for (int c = 0; c < 4; c++)
          for (int k = 0; k < 4; k++) t[4*c+k] = fwd_sb[s[4*((c+k)%4)+k]];
        s = t;
        if (r < num_rounds)
          for (int c = 0; c < 4; c++) begin
            w = mix_column({s[4*c], s[4*c+1], s[4*c+2], s[4*c+3]}, 1'b0);
            {s[4*c], s[4*c+1], s[4*c+2], s[4*c+3]} = w;
          end
        for (int j = 0; j < 16; j++) s[j] ^= round_keys[4*r+j/4][31-8*(j%4) -: 8];
      end
    end else begin
      for (int j = 0; j < 16; j++)
        s[j] ^= round_keys[4*num_rounds+j/4][31-8*(j%4) -: 8];
      for (int r = num_rounds - 1; r >= 0; r--) begin
        for (int c = 0; c < 4; c++)
          for (int k = 0; k < 4; k++) t[4*((c+k)%4)+k] = inv_sb[s[4*c+k]];
        s = t;
        for (int j = 0; j < 16; j++) s[j] ^= round_keys[4*r+j/4][31-8*(j%4) -: 8];
        if (r > 0)
          for (int c = 0; c < 4; c++) begin
            w = mix_column({s[4*c], s[4*c+1], s[4*c+2], s[4*c+3]}, 1'b1);
            {s[4*c], s[4*c+1], s[4*c+2], s[4*c+3]} = w;
          end
      end
    end
    for (int j = 0; j < 16; j++) blk[127-8*j -: 8] = s[j];
    return blk;
  endfunction

  // expected result of one accepted block, with chaining
  function void predict_block(blk_item_t it);
    logic [127:0] x, y;
    bit dec, cbc;
    dec = reg_shadow[REG_MODE][0];
    cbc = reg_shadow[REG_MODE][1];
    expand_schedule();
    if (it.restart) chain_shadow = {reg_shadow[REG_IVH], reg_shadow[REG_IVL]};
    x = {it.hi, it.lo};
    if (cbc && !dec) begin
      y = run_cipher(x ^ chain_shadow, 1'b0);
      chain_shadow = y;
    end else if (cbc) begin
      y = run_cipher(x, 1'b1) ^ chain_shadow;
      chain_shadow = x;
    end else begin
      y = run_cipher(x, dec);
    end
    cipher_out_q.push_back('{y[127:64], y[63:0], it.last});
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [63:0] rand_word();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // input driver fed from block_q
  int tx_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_block(cur_block);
        tx_gap = pick_gap();
      end
      if (in_valid_i && !in_ready_o) begin
        // hold the offer
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_valid_i <= 1'b0;
      end else if (block_q.size() > 0) begin
        cur_block = block_q.pop_front();
        block_high_i <= cur_block.hi;
        block_low_i <= cur_block.lo;
        chain_restart_i <= cur_block.restart;
        final_block_i <= cur_block.last;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result monitor and checker, with one long hold-off
  int rx_hold = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    blk_result_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_out++;
        if (cipher_out_q.size() == 0) begin
          $error("result transfer with nothing expected");
          err_cnt++;
        end else begin
          e = cipher_out_q.pop_front();
          if (out_high_o !== e.hi) begin
            $error("out_high exp %h got %h", e.hi, out_high_o);
            err_cnt++;
          end
          if (out_low_o !== e.lo) begin
            $error("out_low exp %h got %h", e.lo, out_low_o);
            err_cnt++;
          end
          if (out_last_o !== e.last) begin
            $error("out_last exp %b got %b", e.last, out_last_o);
            err_cnt++;
          end
        end
        rx_hold = (n_out == 60) ? 400 : pick_gap();
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
          || (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    reg_shadow[idx] = val;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all(input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] k2, input logic [63:0] k3,
                           input logic [1:0] klen, input logic [1:0] mode,
                           input logic [63:0] ivh, input logic [63:0] ivl);
    write_reg(REG_KEY0, k0);
    write_reg(REG_KEY1, k1);
    write_reg(REG_KEY2, k2);
    write_reg(REG_KEY3, k3);
    write_reg(REG_KLEN, {62'd0, klen});
    write_reg(REG_MODE, {62'd0, mode});
    write_reg(REG_IVH, ivh);
    write_reg(REG_IVL, ivl);
  endtask

  task automatic add_block(input logic [63:0] hi, input logic [63:0] lo,
                           input logic restart, input logic last);
    block_q.push_back('{hi, lo, restart, last});
  endtask

  // every queued block sent and every result back
  task automatic drain();
    while (block_q.size() > 0 || in_valid_i || cipher_out_q.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    int len;
    for (int i = 0; i < 8; i++) reg_shadow[i] = '0;
    chain_shadow = '0;
    build_boxes();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // cbc encrypt straight after reset uses a zero chain value
    write_reg(REG_MODE, {62'd0, MODE_CBC_ENC});
    add_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0, 1'b0);
    add_block('0, '0, 1'b0, 1'b1);
    drain();
    // 128-bit key, ecb encrypt, field extremes and a restart that ecb ignores
    write_all(64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1, KLEN_128, MODE_ECB_ENC,
              64'hfedcba9876543210, 64'h0123456789abcdef);
    add_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0, 1'b0);
    add_block('0, '0, 1'b1, 1'b1);
    add_block('1, '1, 1'b0, 1'b1);
    add_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b1, 1'b0);
    drain();
    // 192-bit key, ecb decrypt
    write_all(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617, '1,
              KLEN_192, MODE_ECB_DEC, '0, '0);
    add_block(64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191, 1'b0, 1'b1);
    add_block('1, '0, 1'b0, 1'b0);
    add_block('0, '1, 1'b1, 1'b1);
    drain();
    // 256-bit key, cbc encrypt message
    write_all('1, '1, '1, '1, KLEN_256, MODE_CBC_ENC, '1, '1);
    add_block('0, '0, 1'b1, 1'b0);
    add_block(64'h0123456789abcdef, 64'h0, 1'b0, 1'b0);
    add_block('1, '1, 1'b0, 1'b1);
    drain();
    // length code three, cbc decrypt; the length write rebuilds the schedule
    write_reg(REG_KLEN, {62'd0, KLEN_ODD});
    write_reg(REG_MODE, {62'd0, MODE_CBC_DEC});
    add_block(64'h1111111111111111, 64'h2222222222222222, 1'b1, 1'b0);
    add_block('1, '0, 1'b0, 1'b0);
    add_block('0, '0, 1'b0, 1'b1);
    drain();
    write_all('0, '0, '0, '0, KLEN_128, MODE_CBC_DEC, '0, '0);
    add_block('0, '0, 1'b1, 1'b1);
    add_block('1, '1, 1'b0, 1'b1);
    drain();

    // random phases of messages under changing settings
    for (int ph = 0; ph < 16; ph++) begin
      for (int r = 0; r < 8; r++)
        if (ph == 0 || $urandom_range(0, 1)) begin
          if (r == REG_KLEN || r == REG_MODE)
            write_reg(r[2:0], {62'd0, 2'($urandom_range(0, 3))});
          else
            write_reg(r[2:0], rand_word());
        end
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 47; n += len) begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0)
            add_block(rand_word(), rand_word(), 1'($urandom), 1'($urandom));
          else
            add_block(rand_word(), rand_word(), k == 0, k == len - 1);
        end
      end
      drain();
    end
    no_gaps = 1'b0;

    repeat (100) @(posedge clk_i);
    if (err_cnt == 0 && cipher_out_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
